/* hdl/e2bv_pkg.sv */
// Shared constants, fixed-point helpers and the arctangent table of the basis-vector block.
// Both hdl/e2bv_sincos.sv and hdl/euler_to_basis_vectors.sv import this package.
`timescale 1ns / 1ps

package e2bv_pkg;

    // Angle units are 1/64 degree.
    localparam int FULL_TURN    = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;

    // CORDIC constants: table length, start value of x (gain in Q30), and +1.0 in Q30.
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    // Width of the CORDIC x and y datapath.
    localparam int XY_W = 34;
    // Width of a Q30 sine, cosine or product.
    localparam int Q30_W = 32;

    typedef logic signed [Q30_W-1:0] t_q30;
    typedef logic signed [15:0]      t_q15;

    // atan(2^-i) in units of 2^-22 degree, rounded to nearest.
    function automatic logic signed [31:0] f_atan(input int i);
        logic signed [31:0] v;
        unique case (i)
            0:  v = 32'sd188743680;
            1:  v = 32'sd111421900;
            2:  v = 32'sd58872272;
            3:  v = 32'sd29884485;
            4:  v = 32'sd15000234;
            5:  v = 32'sd7507429;
            6:  v = 32'sd3754631;
            7:  v = 32'sd1877430;
            8:  v = 32'sd938729;
            9:  v = 32'sd469366;
            10: v = 32'sd234683;
            11: v = 32'sd117342;
            12: v = 32'sd58671;
            13: v = 32'sd29335;
            14: v = 32'sd14668;
            15: v = 32'sd7334;
            16: v = 32'sd3667;
            17: v = 32'sd1833;
            18: v = 32'sd917;
            19: v = 32'sd458;
            20: v = 32'sd229;
            21: v = 32'sd115;
            22: v = 32'sd57;
            23: v = 32'sd29;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Q30 product, rounded with ties up. Operands stay within +-1.0, so the result does too.
    function automatic t_q30 f_mul30(input t_q30 a, input t_q30 b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return p[61:30];
    endfunction

    // Round a Q30 value to Q15 and saturate to the 16-bit range.
    function automatic t_q15 f_to_q15(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [19:0] q;
        t = 35'(v) + 35'sd16384;
        q = t[34:15];
        if (q > 20'sd32767) begin
            return 16'sd32767;
        end else if (q < -20'sd32768) begin
            return -16'sd32768;
        end
        return q[15:0];
    endfunction

endpackage

/* hdl/e2bv_sincos.sv */
// Pipelined sine and cosine of one angle: range reduction, fold, CORDIC stages, clamp.
// Depends on e2bv_pkg for the arctangent table and fixed-point constants.
`timescale 1ns / 1ps

module e2bv_sincos #(
    parameter int STAGES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [15:0]  i_angle,
    output logic                o_valid,
    output e2bv_pkg::t_q30      o_sin,
    output e2bv_pkg::t_q30      o_cos
);
    import e2bv_pkg::*;

    localparam int RUN = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

    logic signed [16:0] r_red;
    logic               r_red_v;
    logic signed [16:0] n_red;

    logic signed [XY_W-1:0] r_x [0:RUN];
    logic signed [XY_W-1:0] r_y [0:RUN];
    logic signed [31:0]     r_z [0:RUN];
    logic                   r_neg [0:RUN];
    logic                   r_v [0:RUN];

    logic signed [16:0] n_fold;
    logic               n_neg;

    logic               r_out_v;
    t_q30               r_sin;
    t_q30               r_cos;
    logic signed [XY_W-1:0] n_xc;
    logic signed [XY_W-1:0] n_yc;

    // Reduce the angle into [-180, 180) degrees with one add or subtract.
    always_comb begin
        n_red = 17'(i_angle);
        if (n_red >= 17'(HALF_TURN)) begin
            n_red = n_red - 17'(FULL_TURN);
        end else if (n_red < -17'(HALF_TURN)) begin
            n_red = n_red + 17'(FULL_TURN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_v <= 1'b0;
        end else if (i_en) begin
            r_red_v <= i_valid;
        end
        if (i_en) begin
            r_red <= n_red;
        end
    end

    // Fold the outer quadrants into [-90, 90] degrees; the cosine is negated there.
    always_comb begin
        n_fold = r_red;
        n_neg  = 1'b0;
        if (r_red > 17'(QUARTER_TURN)) begin
            n_fold = 17'(HALF_TURN) - r_red;
            n_neg  = 1'b1;
        end else if (r_red < -17'(QUARTER_TURN)) begin
            n_fold = -17'(HALF_TURN) - r_red;
            n_neg  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r_red_v;
        end
        if (i_en) begin
            r_x[0]   <= CORDIC_GAIN_Q30;
            r_y[0]   <= '0;
            r_z[0]   <= {n_fold[15:0], 16'b0};
            r_neg[0] <= n_neg;
        end
    end

    // One rotation per stage, each stage registered.
    for (genvar g = 0; g < RUN; g++) begin : g_stage
        logic signed [XY_W-1:0] w_dx;
        logic signed [XY_W-1:0] w_dy;
        assign w_dx = r_y[g] >>> g;
        assign w_dy = r_x[g] >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                if (!r_z[g][31]) begin
                    r_x[g+1] <= r_x[g] - w_dx;
                    r_y[g+1] <= r_y[g] + w_dy;
                    r_z[g+1] <= r_z[g] - f_atan(g);
                end else begin
                    r_x[g+1] <= r_x[g] + w_dx;
                    r_y[g+1] <= r_y[g] - w_dy;
                    r_z[g+1] <= r_z[g] + f_atan(g);
                end
            end
        end
    end

    // Clamp to +-1.0 and apply the quadrant sign of the cosine.
    always_comb begin
        n_xc = r_x[RUN];
        n_yc = r_y[RUN];
        if (n_xc > ONE_Q30) begin
            n_xc = ONE_Q30;
        end else if (n_xc < -ONE_Q30) begin
            n_xc = -ONE_Q30;
        end
        if (n_yc > ONE_Q30) begin
            n_yc = ONE_Q30;
        end else if (n_yc < -ONE_Q30) begin
            n_yc = -ONE_Q30;
        end
        if (r_neg[RUN]) begin
            n_xc = -n_xc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[RUN];
        end
        if (i_en) begin
            r_sin <= n_yc[Q30_W-1:0];
            r_cos <= n_xc[Q30_W-1:0];
        end
    end

    assign o_valid = r_out_v;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

`ifndef NO_ASSERTIONS
    // A clamped sine never leaves +-1.0.
    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_sin <= 32'sd1073741824 && r_sin >= -32'sd1073741824))
        else $error("sine out of range");
    // The first stage always starts from the CORDIC gain.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> (r_x[0] == CORDIC_GAIN_Q30 && r_y[0] == '0))
        else $error("CORDIC start value wrong");
    // A folded angle stays within a quarter turn.
    a_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_red_v) |-> (n_fold <= 17'sd5760 && n_fold >= -17'sd5760))
        else $error("fold out of range");
`endif

endmodule

/* hdl/euler_to_basis_vectors.sv */
// Top level: three sine/cosine pipelines, two product layers and the Q15 output register.
// Depends on e2bv_pkg and e2bv_sincos.
`timescale 1ns / 1ps

// Converts pitch, yaw and roll (signed, 1/64 degree) into the forward, right and up
// unit vectors as nine signed Q1.15 components.
// Input channel s_axis: one item per orientation, taken when tvalid and tready are high.
// Output channel m_axis: one item per input item, in order, held until tready is high.
// Pipeline: CORDIC_STAGES + 6 register stages, with CORDIC_STAGES limited to 24
//   (two reduction stages, the CORDIC stages, the clamp, two multiplier layers and the
//   output register).
// Throughput: one item per cycle while the output is not stalled; every stage is one
//   register deep and the pipeline advances on a shared enable.
// When the receiver stalls with a result waiting, the whole pipeline holds and
//   s_axis_tready drops; empty stages keep no data, so nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; no result is shown after it.
// Each multiplier layer holds 32 x 32 bit products followed by a register.
module euler_to_basis_vectors #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pitch_deg [15:0], yaw_deg [31:16], roll_deg [47:32]
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fwd_x, fwd_y, fwd_z, right_x, right_y, right_z, up_x, up_y, up_z, 16 bits each from bit 0
    output logic [143:0] m_axis_tdata
);
    import e2bv_pkg::*;

    logic w_adv;
    logic w_v_sp, w_v_sy, w_v_sr;
    t_q30 w_sp, w_cp, w_sy, w_cy, w_sr, w_cr;

    // Layer 1 products.
    logic r_v1;
    t_q30 r_cpcy, r_cpsy, r_spcy, r_spsy, r_crsy, r_crcy, r_srsy, r_srcy, r_srcp, r_crcp;
    t_q30 r_sp1, r_sr1, r_cr1;

    // Layer 2 products.
    logic r_v2;
    t_q30 r_srspcy, r_crspcy, r_srspsy, r_crspsy;
    t_q30 r2_cpcy, r2_cpsy, r2_crsy, r2_crcy, r2_srsy, r2_srcy, r2_srcp, r2_crcp, r2_sp;

    logic         r_out_v;
    logic [143:0] r_out;
    logic [143:0] n_out;

    // The pipeline advances unless a finished item waits at a stalled output.
    assign w_adv         = !r_out_v || m_axis_tready;
    assign s_axis_tready = w_adv;

    e2bv_sincos #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(s_axis_tvalid),
        .i_angle(s_axis_tdata[15:0]), .o_valid(w_v_sp), .o_sin(w_sp), .o_cos(w_cp)
    );
    e2bv_sincos #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(s_axis_tvalid),
        .i_angle(s_axis_tdata[31:16]), .o_valid(w_v_sy), .o_sin(w_sy), .o_cos(w_cy)
    );
    e2bv_sincos #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(s_axis_tvalid),
        .i_angle(s_axis_tdata[47:32]), .o_valid(w_v_sr), .o_sin(w_sr), .o_cos(w_cr)
    );

    // First product layer: all pitch-yaw and roll-yaw pairwise terms, and the roll terms times cos(pitch).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_v_sp;
        end
        if (w_adv) begin
            r_cpcy <= f_mul30(w_cp, w_cy);
            r_cpsy <= f_mul30(w_cp, w_sy);
            r_spcy <= f_mul30(w_sp, w_cy);
            r_spsy <= f_mul30(w_sp, w_sy);
            r_crsy <= f_mul30(w_cr, w_sy);
            r_crcy <= f_mul30(w_cr, w_cy);
            r_srsy <= f_mul30(w_sr, w_sy);
            r_srcy <= f_mul30(w_sr, w_cy);
            r_srcp <= f_mul30(w_sr, w_cp);
            r_crcp <= f_mul30(w_cr, w_cp);
            r_sp1  <= w_sp;
            r_sr1  <= w_sr;
            r_cr1  <= w_cr;
        end
    end

    // Second product layer: roll terms times the sin(pitch) pitch-yaw products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
        if (w_adv) begin
            r_srspcy <= f_mul30(r_sr1, r_spcy);
            r_crspcy <= f_mul30(r_cr1, r_spcy);
            r_srspsy <= f_mul30(r_sr1, r_spsy);
            r_crspsy <= f_mul30(r_cr1, r_spsy);
            r2_cpcy  <= r_cpcy;
            r2_cpsy  <= r_cpsy;
            r2_crsy  <= r_crsy;
            r2_crcy  <= r_crcy;
            r2_srsy  <= r_srsy;
            r2_srcy  <= r_srcy;
            r2_srcp  <= r_srcp;
            r2_crcp  <= r_crcp;
            r2_sp    <= r_sp1;
        end
    end

    // Final sums, rounding to Q15 and saturation.
    always_comb begin
        n_out[15:0]    = f_to_q15(34'(r2_cpcy));
        n_out[31:16]   = f_to_q15(34'(r2_cpsy));
        n_out[47:32]   = f_to_q15(-34'(r2_sp));
        n_out[63:48]   = f_to_q15(34'(r2_crsy) - 34'(r_srspcy));
        n_out[79:64]   = f_to_q15(-34'(r_srspsy) - 34'(r2_crcy));
        n_out[95:80]   = f_to_q15(-34'(r2_srcp));
        n_out[111:96]  = f_to_q15(34'(r_crspcy) + 34'(r2_srsy));
        n_out[127:112] = f_to_q15(34'(r_crspsy) - 34'(r2_srcy));
        n_out[143:128] = f_to_q15(34'(r2_crcp));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_v2;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

`ifndef NO_ASSERTIONS
    // The three angle pipelines run in lockstep.
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v_sp == w_v_sy) && (w_v_sp == w_v_sr))
        else $error("sine/cosine pipelines out of step");
    // A waiting result at a stalled output blocks new input items.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline stalled");
    // A stalled output keeps its item.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !m_axis_tready) |=> (r_out_v && $stable(r_out)))
        else $error("stalled result changed");
    // Reset leaves no result on the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_v)
        else $error("result valid after reset");
`endif

endmodule

/* tb/sv/e2bv_checker.sv */
// Checker for euler_to_basis_vectors: watches both stream channels, predicts each result.
// Depends on e2bv_pkg for the Q15 type; the prediction is its own bit-accurate CORDIC model.
`timescale 1ns / 1ps

module e2bv_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [47:0]  i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [143:0] i_out_data,
    output int           o_errors,
    output int           o_pending
);
    import e2bv_pkg::*;

    // Arctangent of 2^-i in 2^-22 degree units.
    localparam longint ATAN_LUT [24] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    logic [143:0] vectors_q[$];
    string        field_names [9] = '{"fwd_x", "fwd_y", "fwd_z", "right_x", "right_y",
                                      "right_z", "up_x", "up_y", "up_z"};

    // Clamp a Q30 value to +-1.0; arithmetic shift of a signed 64-bit value is a floor division.
    function automatic longint clamp_unit(input longint v);
        if (v > 64'sd1073741824) return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    // Sine and cosine in Q30 of an angle in 1/64 degree, with quadrant folding.
    function automatic void angle_sin_cos(input logic signed [15:0] ang, output longint s,
                                          output longint c);
        longint r, x, y, z, dx, dy;
        bit     flip;
        r = ((longint'(ang) % 23040) + 23040) % 23040;
        flip = 0;
        x = 652032874;
        y = 0;
        if (r >= 11520) r -= 23040;
        if (r > 5760) begin
            r = 11520 - r;
            flip = 1;
        end else if (r < -5760) begin
            r = -11520 - r;
            flip = 1;
        end
        z = r * 65536;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_LUT[i];
            end else begin
                x += dx; y -= dy; z += ATAN_LUT[i];
            end
        end
        x = clamp_unit(x);
        s = clamp_unit(y);
        c = flip ? -x : x;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    function automatic t_q15 round_q15(input longint v);
        longint q;
        q = (v + 16384) >>> 15;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return t_q15'(q);
    endfunction

    // Forward, right and up vectors of one orientation.
    function automatic logic [143:0] basis_vectors(input logic [47:0] angles);
        longint sp, cp, sy, cy, sr, cr, spcy, spsy;
        longint comp [9];
        logic [143:0] packed_out;
        angle_sin_cos(angles[15:0], sp, cp);
        angle_sin_cos(angles[31:16], sy, cy);
        angle_sin_cos(angles[47:32], sr, cr);
        spcy = mul_q30(sp, cy);
        spsy = mul_q30(sp, sy);
        comp[0] = mul_q30(cp, cy);
        comp[1] = mul_q30(cp, sy);
        comp[2] = -sp;
        comp[3] = -mul_q30(sr, spcy) + mul_q30(cr, sy);
        comp[4] = -mul_q30(sr, spsy) - mul_q30(cr, cy);
        comp[5] = -mul_q30(sr, cp);
        comp[6] = mul_q30(cr, spcy) + mul_q30(sr, sy);
        comp[7] = mul_q30(cr, spsy) - mul_q30(sr, cy);
        comp[8] = mul_q30(cr, cp);
        for (int i = 0; i < 9; i++) packed_out[16*i +: 16] = round_q15(comp[i]);
        return packed_out;
    endfunction

    // Predict on each accepted input item, compare on each accepted result.
    always @(posedge i_clk) begin
        logic [143:0] want;
        int           errs;
        errs = 0;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_pending <= 0;
            vectors_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) vectors_q.push_back(basis_vectors(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (vectors_q.size() == 0) begin
                    $error("result with no expected item: %h", i_out_data);
                    errs++;
                end else begin
                    want = vectors_q.pop_front();
                    for (int i = 0; i < 9; i++) begin
                        if (want[16*i +: 16] !== i_out_data[16*i +: 16]) begin
                            $error("%s expected %0d actual %0d", field_names[i],
                                   $signed(want[16*i +: 16]), $signed(i_out_data[16*i +: 16]));
                            errs++;
                        end
                    end
                end
            end
            o_errors  <= o_errors + errs;
            o_pending <= vectors_q.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
// Top of the basis-vector testbench: clock, reset, stimulus and verdict.
// Depends on euler_to_basis_vectors, e2bv_checker and e2bv_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int  STAGES      = 16;
    localparam int  RAND_ITEMS  = 1950;
    localparam int  DRAIN_WAIT  = STAGES + 20;
    localparam longint CYCLE_LIMIT = 200000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_valid = 0;
    logic         s_ready;
    logic [47:0]  s_data = '0;
    logic         m_valid;
    logic         m_ready = 0;
    logic [143:0] m_data;
    int           errors;
    int           pending;
    longint       cycles = 0;

    always #5 i_clk = ~i_clk;

    euler_to_basis_vectors #(.CORDIC_STAGES(STAGES)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data)
    );

    e2bv_checker #(.CORDIC_STAGES(STAGES)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .o_errors(errors), .o_pending(pending)
    );

    // Run timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stall pattern: free-running phases, some without any stalls.
    always @(negedge i_clk) begin
        int mode;
        mode = (cycles / 500) % 4;
        case (mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 1) != 0);
            default: m_ready <= (cycles % 7 < 2);
        endcase
    end

    // Hold one item on the bus until accepted; a gap may follow.
    task automatic send_angles(input logic [47:0] angles, input int gap);
        s_data  <= angles;
        s_valid <= 1'b1;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(0, 8)) * 16'sd2880 - 16'sd11520);
            2:       return 16'($urandom_range(0, 16) - 8 + 5760);
            3:       return 16'(-5760 + int'($urandom_range(0, 16)) - 8);
            default: return 16'($urandom_range(0, 46080) - 23040);
        endcase
    endfunction

    logic [15:0] corner [12] = '{16'sd0, 16'sd5760, -16'sd5760, 16'sd11520, -16'sd11520,
                                 16'sd23040, -16'sd23040, 16'sd32767, -16'sd32768,
                                 16'sd5761, -16'sd5761, 16'sd1};

    initial begin
        int burst;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: corner angles on each axis, then mixed.
        for (int i = 0; i < 12; i++)
            send_angles({corner[i], corner[(i + 3) % 12], corner[(i + 7) % 12]}, 0);
        send_angles({16'hFFFF, 16'hFFFF, 16'hFFFF}, 0);
        send_angles({16'h5555, 16'hAAAA, 16'h0F0F}, 0);
        send_angles({16'd1920, 16'd2880, 16'd3840}, 1);

        // Pause until the pipeline has drained completely.
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // Random bursts with random gaps.
        burst = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (burst == 0) burst = $urandom_range(1, 40);
            burst--;
            send_angles({pick_angle(), pick_angle(), pick_angle()},
                        (burst == 0) ? $urandom_range(1, 12) : 0);
        end
        s_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* euler_to_basis_vectors.f */
hdl/e2bv_pkg.sv
hdl/e2bv_sincos.sv
hdl/euler_to_basis_vectors.sv
tb/sv/e2bv_checker.sv
tb/sv/testbench.sv
